### hdl/binary_to_decimal_ascii_defines.svh
// assertion macros for the binary to decimal ascii converter
// used by the top level; expects clk_i and rst_ni in the including scope
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define B2DA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define B2DA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/b2da_pkg.sv
// shared types and constants for the binary to decimal ascii converter
// no dependencies
package b2da_pkg;

  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned CHAR_W  = 6;

  // ascii '0' within the 6-bit character field
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  typedef logic [DIGIT_W-1:0] digit_t;

  // per-cycle command broadcast to every digit cell
  typedef struct packed {
    logic clear;   // zero the digit
    logic dabble;  // add-3 correction then shift one bit in
    logic shift;   // take the neighbor's digit
  } ctrl_t;

endpackage

### hdl/b2da_cell.sv
// one bcd digit cell of the double-dabble chain
// depends on b2da_pkg
module b2da_cell (
  input  logic             clk_i,
  input  b2da_pkg::ctrl_t  ctrl_i,
  input  logic             bit_i,
  input  b2da_pkg::digit_t digit_i,
  output logic             bit_o,
  output b2da_pkg::digit_t digit_o
);

  b2da_pkg::digit_t digit_q, digit_d, adj;

  assign adj     = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
  assign bit_o   = adj[3];
  assign digit_o = digit_q;

  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.dabble) begin
      digit_d = {adj[2:0], bit_i};
    end else if (ctrl_i.shift) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

endmodule

### hdl/binary_to_decimal_ascii.sv
// top level of the binary to decimal ascii converter
// depends on b2da_pkg, b2da_cell and binary_to_decimal_ascii_defines.svh
//
// usage:
//   a request is taken at a rising edge with start high and busy low; value_i
//   carries the unsigned number, only its low VALUE_WIDTH bits are used.
//   the decimal text comes out most significant digit first on digit_char_o,
//   one character per valid_o strobe, leading zeros dropped; zero gives a
//   single '0'. last_o marks the least significant character.
//   conversion: bit-serial double dabble of all VALUE_WIDTH bits through a row
//   of NUM_DIGITS bcd digit cells, then an emit phase in which the row shifts
//   up one digit per cycle and the top digit is emitted or skipped.
//   busy stays high through both phases from the edge that takes a request,
//   so no new request is taken while a conversion is in flight; the first
//   character shows in the cycle after the first nonzero digit reaches the
//   top. busy drops as the last character is shown, so the next request
//   can be taken in that cycle.
//   results cannot be held off: each strobe lasts exactly one cycle.
//   reset returns the controller to idle and drops the strobe; nothing else
//   is kept between requests.
`include "binary_to_decimal_ascii_defines.svh"
module binary_to_decimal_ascii #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [63:0]                  value_i,
  output logic [b2da_pkg::CHAR_W-1:0]  digit_char_o,
  output logic                         last_o,
  output logic                         valid_o
);

  // digits of 2^VALUE_WIDTH - 1: floor(w * log10 2) + 1
  localparam int unsigned NUM_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned BIT_CNT_W   = $clog2(VALUE_WIDTH);
  localparam int unsigned DIGIT_CNT_W = $clog2(NUM_DIGITS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]             state_q, state_d;
  logic [BIT_CNT_W-1:0]   bit_cnt_q, bit_cnt_d;
  logic [DIGIT_CNT_W-1:0] pos_q, pos_d;
  logic                   started_q, started_d;
  logic                   valid_q, valid_d;
  logic                   last_q, last_d;
  logic [VALUE_WIDTH-1:0] value_q, value_d;
  b2da_pkg::digit_t       char_digit_q, char_digit_d;

  logic                   accept;
  logic                   pos_last;
  logic                   show;
  b2da_pkg::ctrl_t        ctrl;

  logic             [NUM_DIGITS:0]   carry;
  b2da_pkg::digit_t [NUM_DIGITS-1:0] digits;
  b2da_pkg::digit_t [NUM_DIGITS:0]   digit_chain;

  assign accept   = start && !busy;
  assign busy     = (state_q != ST_IDLE);
  assign pos_last = (pos_q == DIGIT_CNT_W'(NUM_DIGITS - 1));
  // emit once the first nonzero digit is seen, or the ones digit regardless
  assign show     = started_q || (digits[NUM_DIGITS-1] != '0) || pos_last;

  assign carry[0]       = value_q[VALUE_WIDTH-1];
  assign digit_chain[0] = '0;

  for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
    b2da_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .bit_i   (carry[g]),
      .digit_i (digit_chain[g]),
      .bit_o   (carry[g+1]),
      .digit_o (digits[g])
    );
    assign digit_chain[g+1] = digits[g];
  end

  always_comb begin
    state_d      = state_q;
    bit_cnt_d    = bit_cnt_q;
    pos_d        = pos_q;
    started_d    = started_q;
    value_d      = value_q;
    valid_d      = 1'b0;
    last_d       = 1'b0;
    char_digit_d = char_digit_q;
    ctrl         = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          value_d    = value_i[VALUE_WIDTH-1:0];
          bit_cnt_d  = '0;
          ctrl.clear = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.dabble = 1'b1;
        value_d     = {value_q[VALUE_WIDTH-2:0], 1'b0};
        bit_cnt_d   = bit_cnt_q + 1'b1;
        if (bit_cnt_q == BIT_CNT_W'(VALUE_WIDTH - 1)) begin
          pos_d     = '0;
          started_d = 1'b0;
          state_d   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        ctrl.shift   = 1'b1;
        pos_d        = pos_q + 1'b1;
        valid_d      = show;
        last_d       = pos_last;
        char_digit_d = digits[NUM_DIGITS-1];
        started_d    = show;
        if (pos_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      valid_q   <= 1'b0;
      started_q <= 1'b0;
      bit_cnt_q <= '0;
      pos_q     <= '0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      started_q <= started_d;
      bit_cnt_q <= bit_cnt_d;
      pos_q     <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q      <= value_d;
    last_q       <= last_d;
    char_digit_q <= char_digit_d;
  end

  assign valid_o      = valid_q;
  assign last_o       = last_q;
  assign digit_char_o = b2da_pkg::ASCII_ZERO | {2'b00, char_digit_q};

  `B2DA_ASSERT_NOW(a_char_is_digit, valid_o, char_digit_q <= 4'd9, "bcd digit out of range")
  `B2DA_ASSERT_NOW(a_last_frees, valid_o && last_o, !busy, "busy after last character")
  `B2DA_ASSERT_NOW(a_more_pending, valid_o && !last_o, busy, "idle with characters pending")
  `B2DA_ASSERT_NEXT(a_accept_quiet, accept, busy && !valid_o, "bad state after request")

endmodule

### verif/binary_to_decimal_ascii_test.sv
// self-checking testbench for binary_to_decimal_ascii: directed and random numbers
// are converted to decimal text on the side and checked against each output character
// depends on b2da_pkg and the binary_to_decimal_ascii top level
`timescale 1ns / 100ps

module binary_to_decimal_ascii_test;

  localparam int unsigned VALUE_WIDTH = 64;
  localparam int unsigned MAX_DIGITS  = 20;
  localparam int unsigned TAIL_CYCLES = 120;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned REPORT_MAX  = 10;

  typedef struct {
    logic [63:0] number;
    int unsigned idle_pct;
  } conv_req_t;

  typedef struct {
    logic [b2da_pkg::CHAR_W-1:0] digit_char;
    logic                        last;
  } text_char_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start;
  logic                        busy;
  logic [63:0]                 value_i;
  logic [b2da_pkg::CHAR_W-1:0] digit_char_o;
  logic                        last_o;
  logic                        valid_o;

  conv_req_t   req_q[$];
  text_char_t  text_q[$];
  bit          req_taken;
  int unsigned fail_cnt;
  int unsigned cycle_cnt;

  binary_to_decimal_ascii #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .value_i     (value_i),
    .digit_char_o(digit_char_o),
    .last_o      (last_o),
    .valid_o     (valid_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // decimal text of one number, most significant digit first, queued as expected chars
  task automatic expand_decimal(input logic [63:0] number);
    logic [63:0] rest;
    logic [3:0]  rev_digits[MAX_DIGITS];
    int unsigned n_digits;
    text_char_t  ch;
    rest = number & ({64{1'b1}} >> (64 - VALUE_WIDTH));
    n_digits = 0;
    do begin
      rev_digits[n_digits] = 4'(rest % 64'd10);
      n_digits++;
      rest = rest / 64'd10;
    end while (rest != 64'd0);
    for (int k = n_digits - 1; k >= 0; k--) begin
      ch.digit_char = b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_W'(rev_digits[k]);
      ch.last       = (k == 0);
      text_q.push_back(ch);
    end
  endtask

  task automatic note_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= REPORT_MAX) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // random number, biased toward every digit count and the decade borders
  function automatic logic [63:0] random_number();
    logic [63:0] num;
    logic [63:0] pow10;
    int unsigned w;
    int unsigned kind;
    kind = $urandom_range(9);
    w = $urandom_range(64, 1);
    case (kind)
      0, 1, 2, 3: begin
        num = {$urandom, $urandom} & ({64{1'b1}} >> (64 - w));
      end
      4, 5, 6: begin
        num = {$urandom, $urandom};
      end
      7: begin
        pow10 = 64'd1;
        repeat ($urandom_range(19)) pow10 = pow10 * 64'd10;
        num = pow10 + 64'($urandom_range(4)) - 64'd2;
      end
      8: begin
        num = 64'($urandom_range(999));
      end
      default: begin
        num = {64{1'b1}} >> (64 - w);
      end
    endcase
    return num;
  endfunction

  // request driver: holds a request until taken, random gaps between requests
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !req_taken) begin
      // waiting for the converter to take it
    end else if (req_q.size() != 0 && $urandom_range(99) >= req_q[0].idle_pct) begin
      start   <= 1'b1;
      value_i <= req_q[0].number;
    end else begin
      start   <= 1'b0;
      value_i <= {$urandom, $urandom};
    end
    req_taken = 1'b0;
  end

  // monitor: check each output character, then take a new request
  always @(posedge clk_i) begin
    text_char_t exp_ch;
    cycle_cnt++;
    if (rst_ni) begin
      if (valid_o) begin
        if (text_q.size() == 0) begin
          note_failure($sformatf("unexpected char 0x%0h last %0b", digit_char_o, last_o));
        end else begin
          exp_ch = text_q.pop_front();
          if (digit_char_o !== exp_ch.digit_char) begin
            note_failure($sformatf("digit_char expected 0x%0h got 0x%0h",
                                   exp_ch.digit_char, digit_char_o));
          end
          if (last_o !== exp_ch.last) begin
            note_failure($sformatf("last expected %0b got %0b", exp_ch.last, last_o));
          end
        end
      end
      if (start && !busy) begin
        expand_decimal(value_i);
        void'(req_q.pop_front());
        req_taken = 1'b1;
      end
    end
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [63:0] directed[$];
    conv_req_t   req;
    rst_ni    = 1'b0;
    start     = 1'b0;
    value_i   = 64'd0;
    req_taken = 1'b0;
    fail_cnt  = 0;
    cycle_cnt = 0;

    directed = '{64'd0, 64'd1, 64'd7, 64'd9, 64'd10, 64'd11, 64'd99, 64'd100, 64'd1000,
                 64'd12345, 64'hFFFF_FFFF, 64'h1_0000_0000, 64'd999999999999,
                 64'd999999999999999999, 64'd1000000000000000000,
                 64'd9999999999999999999, 64'd10000000000000000000,
                 64'd12345678901234567890, 64'h7FFF_FFFF_FFFF_FFFF,
                 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
                 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                 64'hFFFF_FFFF_FFFF_FFFF};
    foreach (directed[i]) begin
      req.number   = directed[i];
      req.idle_pct = 0;
      req_q.push_back(req);
    end
    // back to back, then sparse requests, then back to back again, then light gaps
    for (int i = 0; i < 470; i++) begin
      req.number = random_number();
      if (i < 120) req.idle_pct = 0;
      else if (i < 240) req.idle_pct = 78;
      else if (i < 350) req.idle_pct = 0;
      else req.idle_pct = 15;
      req_q.push_back(req);
    end

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (req_q.size() != 0 || text_q.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (text_q.size() != 0) begin
      note_failure($sformatf("%0d chars never came out", text_q.size()));
    end

    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### binary_to_decimal_ascii.f
+incdir+hdl
hdl/b2da_pkg.sv
hdl/b2da_cell.sv
hdl/binary_to_decimal_ascii.sv
verif/binary_to_decimal_ascii_test.sv
